FILE: hw/rtl/json_string_unescaper_top_assert.svh
// Assertion macros for the JSON string unescaper RTL, used by jsu_result_fifo.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef JSON_STRING_UNESCAPER_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define JSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, checked out of reset
`define JSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

FILE: hw/rtl/jsu_pkg.sv
// Package for the JSON string unescaper: widths, codes, result types, helpers.
// No dependencies; used by jsu_decode, jsu_result_fifo and the top level.
package jsu_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_RES    = 4;   // results one item can cause
    localparam int CNT_W      = 3;   // holds 0..MAX_RES
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;   // holds 0..FIFO_DEPTH

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control bytes the short escapes map to
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_NOQUOTE = 2'd2,
        KIND_UNTERM  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        MODE_AWAIT = 4'b0001,
        MODE_BODY  = 4'b0010,
        MODE_ESC   = 4'b0100,
        MODE_HEX   = 4'b1000
    } mode_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
        logic              last;
    } res_t;

    // All results caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        res_t [MAX_RES-1:0]     ent;
    } group_t;

    typedef struct packed {
        logic [1:0]             n;
        logic [2:0][BYTE_W-1:0] b;
    } utf8_t;

    // Hex digit value; anything that is not a hex digit counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        case (h) inside
            [8'h30:8'h39]: v = h[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: v = h[3:0] + 4'd9;
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

    // UTF-8 encoding of a BMP code point, 1 to 3 bytes
    function automatic utf8_t utf8_encode(input logic [15:0] cp);
        utf8_t u;
        u = '0;
        if (cp[15:7] == 9'd0) begin
            u.n    = 2'd1;
            u.b[0] = {1'b0, cp[6:0]};
        end
        else if (cp[15:11] == 5'd0) begin
            u.n    = 2'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end
        else begin
            u.n    = 2'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

FILE: hw/rtl/json_string_unescaper_top.sv
// JSON string unescaper: decodes a string literal one source byte per item.
// An accepted item is held in the input register, then decoded into the result queue, from
// which its first result is shown. Throughput: one item per cycle while the 8-entry result
// queue has room for 4 results; results leave one per cycle while m_tready is high.
// Reset (rst_n low, asynchronous) empties the queue and returns to awaiting a quote.
// Depends on jsu_pkg, jsu_decode, jsu_result_fifo.
module json_string_unescaper_top
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // end_of_source
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] out_byte
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast    // last_of_run
);

    logic    room;
    logic    push;
    group_t  grp;

    // Byte decode with parse state
    jsu_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .room     (room),
        .push     (push),
        .grp      (grp)
    );

    // Result queue and output port
    jsu_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .grp      (grp),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/jsu_decode.sv
// Input register, parse state and one-pass decode of a source byte into its results.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // end_of_source
    input  logic         room,      // result queue can take a full group
    output logic         push,
    output group_t       grp
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;

    mode_t              mode_reg, mode_next;
    logic [1:0]         digits_reg, digits_next;
    logic [15:0]        acc_reg, acc_next;

    logic               consume;
    logic [1:0]         dcnt;
    logic [3:0][7:0]    dbyte;
    logic               term_v;
    kind_t              term_k;
    logic               closed;
    utf8_t              u;
    logic [CNT_W-1:0]   total;

    assign consume  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_AWAIT;
            digits_reg <= 2'd0;
            acc_reg    <= 16'd0;
        end
        else if (consume)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

    // Decode: data bytes first, then at most one status result
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        dcnt        = 2'd0;
        dbyte       = '0;
        term_v      = 1'b0;
        term_k      = KIND_DATA;
        closed      = 1'b0;
        u           = '0;

        case (mode_reg)
            MODE_AWAIT:
            begin
                if (in_byte_reg == CH_QUOTE)
                begin
                    mode_next = MODE_BODY;
                end
                else
                begin
                    term_v = 1'b1;
                    term_k = KIND_NOQUOTE;
                end
            end
            MODE_BODY:
            begin
                if (in_byte_reg == CH_QUOTE)
                begin
                    term_v    = 1'b1;
                    term_k    = KIND_DONE;
                    mode_next = MODE_AWAIT;
                    closed    = 1'b1;
                end
                else if (in_byte_reg == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    dcnt     = 2'd1;
                    dbyte[0] = in_byte_reg;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_BODY;
                dcnt      = 2'd1;
                case (in_byte_reg)
                    CH_N:    dbyte[0] = BYTE_LF;
                    CH_T:    dbyte[0] = BYTE_HT;
                    CH_R:    dbyte[0] = BYTE_CR;
                    CH_B:    dbyte[0] = BYTE_BS;
                    CH_F:    dbyte[0] = BYTE_FF;
                    CH_U:
                    begin
                        mode_next   = MODE_HEX;
                        digits_next = 2'd0;
                        acc_next    = 16'd0;
                        // source ending right after \u gives code point zero
                        dcnt        = in_last_reg ? 2'd1 : 2'd0;
                        dbyte[0]    = 8'd0;
                    end
                    default: dbyte[0] = in_byte_reg;
                endcase
            end
            MODE_HEX:
            begin
                acc_next = {acc_reg[11:0], hex_value(in_byte_reg)};
                u        = utf8_encode(acc_next);
                if (digits_reg == 2'd3 || in_last_reg)
                begin
                    dcnt     = u.n;
                    dbyte[0] = u.b[0];
                    dbyte[1] = u.b[1];
                    dbyte[2] = u.b[2];
                end
                if (digits_reg == 2'd3)
                begin
                    digits_next = 2'd0;
                    mode_next   = MODE_BODY;
                end
                else
                begin
                    digits_next = digits_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next = MODE_AWAIT;
            end
        endcase

        // Source ended while a string was open
        if (in_last_reg && !closed && mode_next != MODE_AWAIT)
        begin
            term_v      = 1'b1;
            term_k      = KIND_UNTERM;
            mode_next   = MODE_AWAIT;
            digits_next = 2'd0;
            acc_next    = 16'd0;
        end
    end

    // Pack the results into one group, marking the final one
    always_comb
    begin
        total   = {1'b0, dcnt} + {2'b00, term_v};
        grp.cnt = total;
        for (int i = 0; i < MAX_RES; i++)
        begin
            grp.ent[i] = '0;
            if (CNT_W'(i) < {1'b0, dcnt})
            begin
                grp.ent[i].data = dbyte[i];
                grp.ent[i].kind = KIND_DATA;
            end
            else if (CNT_W'(i) == {1'b0, dcnt} && term_v)
            begin
                grp.ent[i].data = 8'd0;
                grp.ent[i].kind = term_k;
            end
            grp.ent[i].last = (CNT_W'(i + 1) == total);
        end
    end

    assign push = consume && (total != '0);

endmodule

FILE: hw/rtl/jsu_result_fifo.sv
// Result queue: takes up to four results a cycle, gives one result item a cycle while m_tready is high.
// Depends on jsu_pkg and json_string_unescaper_top_assert.svh.
`include "json_string_unescaper_top_assert.svh"
module jsu_result_fifo
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  group_t       grp,
    output logic         room,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] out_byte
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast    // last_of_run
);

    res_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]     push_cnt;
    logic                 pop;
    res_t                 head;

    assign push_cnt = push ? grp.cnt : '0;
    assign pop      = m_tvalid && m_tready;
    assign room     = count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RES);

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: a group lands in consecutive entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (push && CNT_W'(i) < grp.cnt)
            begin
                mem[wr_ptr_reg + FIFO_AW'(i)] <= grp.ent[i];
            end
        end
    end

    // Output side
    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = head.data;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    `JSU_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH))
    `JSU_ASSERT_IMP(a_push_fits, push, count_reg + FIFO_CW'(grp.cnt) <= FIFO_CW'(FIFO_DEPTH))
    `JSU_ASSERT_NXT(a_push_shows, push && grp.cnt != '0, m_tvalid)

endmodule
